// ===== design/assert_macros.svh =====
// Assertion macros shared by the recognizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define PDR_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("pdr assertion failed");

// Implication checked at every clock edge out of reset.
`define PDR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdr assertion failed");

`endif

// ===== design/pdr_pkg.sv =====
// Package with constants, codes and types of the pushdown recognizer.
`timescale 1ns / 1ps
package pdr_pkg;
	localparam int STACK_DEPTH = 64;
	localparam int STATE_BITS  = 4;
	localparam int SYMBOL_BITS = 4;
	localparam int SP_W   = $clog2(STACK_DEPTH + 1);
	localparam int SA_W   = $clog2(STACK_DEPTH);
	localparam int CI_W   = STATE_BITS + SYMBOL_BITS;
	localparam int KEY_W  = CI_W + SYMBOL_BITS;
	localparam int CNT_W  = $clog2((2 ** SYMBOL_BITS) + 1);
	localparam int NSTATES = 2 ** STATE_BITS;

	localparam logic [2:0] MODE_WRITE  = 3'd0;
	localparam logic [2:0] MODE_DELETE = 3'd1;
	localparam logic [2:0] MODE_START  = 3'd2;
	localparam logic [2:0] MODE_SYMBOL = 3'd3;
	localparam logic [2:0] MODE_END    = 3'd4;
	localparam logic [2:0] MODE_CLEAR  = 3'd5;

	localparam logic [1:0] EV_CHECK = 2'd0;
	localparam logic [1:0] EV_POP   = 2'd1;

	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_ACCEPTED    = 4'd1;
	localparam logic [3:0] ST_NORULE_SYM  = 4'd2;
	localparam logic [3:0] ST_NORULE_TOP  = 4'd3;
	localparam logic [3:0] ST_MISMATCH    = 4'd4;
	localparam logic [3:0] ST_POP_EMPTY   = 4'd5;
	localparam logic [3:0] ST_OVERFLOW    = 4'd6;
	localparam logic [3:0] ST_NO_HALT     = 4'd7;
	localparam logic [3:0] ST_WRITTEN     = 4'd8;
	localparam logic [3:0] ST_EXISTS      = 4'd9;
	localparam logic [3:0] ST_DELETED     = 4'd10;
	localparam logic [3:0] ST_ABSENT      = 4'd11;

	localparam logic [2:0] REG_START_STATE = 3'd0;
	localparam logic [2:0] REG_FINAL_MASK  = 3'd1;
	localparam logic [2:0] REG_BOTTOM_SYM  = 3'd2;
	localparam logic [2:0] REG_END_SYM     = 3'd3;
	localparam logic [2:0] REG_STEP_LIMIT  = 3'd4;

	typedef struct packed {
		logic                   valid;
		logic [STATE_BITS-1:0]  next;
		logic [1:0]             kind;
		logic [SYMBOL_BITS-1:0] first;
		logic [SYMBOL_BITS-1:0] second;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [2:0]             mode;
		logic [STATE_BITS-1:0]  rule_state;
		logic [SYMBOL_BITS-1:0] symbol;
		logic [SYMBOL_BITS-1:0] rule_stack_symbol;
		logic [STATE_BITS-1:0]  rule_next_state;
		logic [1:0]             event_kind;
		logic [SYMBOL_BITS-1:0] event_first;
		logic [SYMBOL_BITS-1:0] event_second;
	} item_t;

	typedef struct packed {
		logic [3:0]             status;
		logic [STATE_BITS-1:0]  current_state;
		logic [SYMBOL_BITS-1:0] stack_top;
		logic [SP_W-1:0]        stack_depth;
	} result_t;

	typedef struct packed {
		logic [STATE_BITS-1:0]  start_state;
		logic [NSTATES-1:0]     final_mask;
		logic [SYMBOL_BITS-1:0] bottom_symbol;
		logic [SYMBOL_BITS-1:0] end_symbol;
		logic [7:0]             end_step_limit;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic start;
		logic rule_upd;
		logic move_apply;
		logic pop_load;
		logic end_init;
		logic end_check;
		logic step_inc;
		logic clr_run;
		logic capture;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       halted;
		logic       move_fail;
		logic       move_pop_ld;
		logic       is_final;
		logic       limit_hit;
		logic       clr_last;
	} sts_t;
endpackage

// ===== design/pdr_in_if.sv =====
// Input channel interface of the recognizer.
`timescale 1ns / 1ps
interface pdr_in_if;
	import pdr_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [2:0]             mode;
	logic [STATE_BITS-1:0]  rule_state;
	logic [SYMBOL_BITS-1:0] symbol;
	logic [SYMBOL_BITS-1:0] rule_stack_symbol;
	logic [STATE_BITS-1:0]  rule_next_state;
	logic [1:0]             event_kind;
	logic [SYMBOL_BITS-1:0] event_first;
	logic [SYMBOL_BITS-1:0] event_second;

	modport source (output valid, mode, rule_state, symbol, rule_stack_symbol,
		rule_next_state, event_kind, event_first, event_second, input ready);
	modport sink (input valid, mode, rule_state, symbol, rule_stack_symbol,
		rule_next_state, event_kind, event_first, event_second, output ready);
endinterface

// ===== design/pdr_out_if.sv =====
// Result channel interface of the recognizer.
`timescale 1ns / 1ps
interface pdr_out_if;
	import pdr_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [3:0]             status;
	logic [STATE_BITS-1:0]  current_state;
	logic [SYMBOL_BITS-1:0] stack_top;
	logic [SP_W-1:0]        stack_depth;

	modport source (output valid, status, current_state, stack_top, stack_depth,
		input ready);
	modport sink (input valid, status, current_state, stack_top, stack_depth,
		output ready);
endinterface

// ===== design/pdr_ram.sv =====
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module pdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/pdr_datapath.sv =====
// Datapath: rule table, rule counts, symbol stack and run registers.
`timescale 1ns / 1ps
module pdr_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  pdr_pkg::cmd_t    cmd,
	input  pdr_pkg::cfg_t    cfg,
	input  pdr_pkg::item_t   item,
	output pdr_pkg::sts_t    sts,
	output pdr_pkg::result_t result
);
	import pdr_pkg::*;

	item_t                  item_q;
	logic [STATE_BITS-1:0]  run_state_q;
	logic [SP_W-1:0]        sp_q;
	logic [SYMBOL_BITS-1:0] top_q;
	logic                   halted_q;
	logic [7:0]             steps_q;
	logic [KEY_W-1:0]       clr_q;
	logic [3:0]             status_q;
	result_t                result_q;

	logic                   is_move;
	logic [SYMBOL_BITS-1:0] move_sym;
	logic [KEY_W-1:0]       key;
	logic [ENTRY_W-1:0]     tbl_rdata;
	logic [ENTRY_W-1:0]     tbl_wdata;
	logic [CNT_W-1:0]       cnt_rdata;
	logic [CNT_W-1:0]       cnt_wdata;
	logic                   rule_we;
	logic                   tbl_we;
	entry_t                 ent;
	logic [3:0]             fail_code;
	logic                   push;
	logic                   stk_we;
	logic [SA_W-1:0]        stk_waddr;
	logic [SYMBOL_BITS-1:0] stk_wdata;
	logic [SA_W-1:0]        stk_raddr;
	logic [SYMBOL_BITS-1:0] stk_rdata;
	logic [SP_W-1:0]        sp_m2;

	assign is_move  = (item_q.mode == MODE_SYMBOL) || (item_q.mode == MODE_END);
	assign move_sym = (item_q.mode == MODE_END) ? cfg.end_symbol : item_q.symbol;
	assign key = is_move ? {run_state_q, move_sym, top_q}
		: {item_q.rule_state, item_q.symbol, item_q.rule_stack_symbol};
	assign ent = entry_t'(tbl_rdata);

	always_comb begin
		rule_we   = 1'b0;
		tbl_wdata = '0;
		cnt_wdata = '0;
		if (cmd.rule_upd) begin
			if (item_q.mode == MODE_WRITE) begin
				rule_we   = !ent.valid;
				tbl_wdata = {1'b1, item_q.rule_next_state, item_q.event_kind,
					item_q.event_first, item_q.event_second};
				cnt_wdata = cnt_rdata + CNT_W'(1);
			end else begin
				rule_we   = ent.valid;
				cnt_wdata = (cnt_rdata != '0) ? cnt_rdata - CNT_W'(1) : '0;
			end
		end
	end

	assign tbl_we = cmd.clr_run || rule_we;

	pdr_ram #(.WIDTH(ENTRY_W), .DEPTH(2 ** KEY_W)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (cmd.clr_run ? clr_q : key),
		.wdata (cmd.clr_run ? '0 : tbl_wdata),
		.raddr (key),
		.rdata (tbl_rdata)
	);

	pdr_ram #(.WIDTH(CNT_W), .DEPTH(2 ** CI_W)) u_count (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (cmd.clr_run ? clr_q[CI_W-1:0] : key[KEY_W-1:SYMBOL_BITS]),
		.wdata (cmd.clr_run ? '0 : cnt_wdata),
		.raddr (key[KEY_W-1:SYMBOL_BITS]),
		.rdata (cnt_rdata)
	);

	always_comb begin
		push = ent.kind[1] && (ent.second == top_q);
		if (cnt_rdata == '0) begin
			fail_code = ST_NORULE_SYM;
		end else if (!ent.valid) begin
			fail_code = ST_NORULE_TOP;
		end else if (ent.kind == EV_CHECK) begin
			fail_code = (ent.first != top_q) ? ST_MISMATCH : ST_OK;
		end else if (ent.kind == EV_POP) begin
			fail_code = (sp_q == '0) ? ST_POP_EMPTY : ST_OK;
		end else begin
			fail_code = (push && (sp_q >= SP_W'(STACK_DEPTH))) ? ST_OVERFLOW : ST_OK;
		end
	end

	assign stk_we    = cmd.start || (cmd.move_apply && (fail_code == ST_OK) && push);
	assign stk_waddr = cmd.start ? '0 : sp_q[SA_W-1:0];
	assign stk_wdata = cmd.start ? cfg.bottom_symbol : ent.first;
	assign sp_m2     = sp_q - SP_W'(2);
	assign stk_raddr = sp_m2[SA_W-1:0];

	pdr_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_state_q <= '0;
			sp_q        <= '0;
			top_q       <= '0;
			halted_q    <= 1'b1;
			steps_q     <= '0;
			clr_q       <= '0;
			status_q    <= ST_OK;
		end else begin
			if (cmd.clr_run) begin
				clr_q <= clr_q + KEY_W'(1);
			end
			if (cmd.load) begin
				status_q <= ST_OK;
			end
			if (cmd.start) begin
				run_state_q <= cfg.start_state;
				sp_q        <= SP_W'(1);
				top_q       <= cfg.bottom_symbol;
				halted_q    <= 1'b0;
			end
			if (cmd.rule_upd) begin
				if (item_q.mode == MODE_WRITE) begin
					status_q <= ent.valid ? ST_EXISTS : ST_WRITTEN;
				end else begin
					status_q <= ent.valid ? ST_DELETED : ST_ABSENT;
				end
			end
			if (cmd.move_apply) begin
				if (fail_code != ST_OK) begin
					status_q <= fail_code;
					halted_q <= 1'b1;
				end else begin
					run_state_q <= ent.next;
					if (ent.kind == EV_POP) begin
						sp_q <= sp_q - SP_W'(1);
						if (sp_q == SP_W'(1)) begin
							top_q <= '0;
						end
					end else if (push) begin
						sp_q  <= sp_q + SP_W'(1);
						top_q <= ent.first;
					end
				end
			end
			if (cmd.pop_load) begin
				top_q <= stk_rdata;
			end
			if (cmd.end_init) begin
				steps_q <= '0;
			end
			if (cmd.step_inc) begin
				steps_q <= steps_q + 8'd1;
			end
			if (cmd.end_check) begin
				if (sts.is_final) begin
					status_q <= ST_ACCEPTED;
					halted_q <= 1'b1;
				end else if (sts.limit_hit) begin
					status_q <= ST_NO_HALT;
					halted_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.capture) begin
			result_q <= '{status: status_q, current_state: run_state_q,
				stack_top: top_q, stack_depth: sp_q};
		end
	end

	assign sts.mode        = item_q.mode;
	assign sts.halted      = halted_q;
	assign sts.move_fail   = (fail_code != ST_OK);
	assign sts.move_pop_ld = (ent.kind == EV_POP) && (sp_q > SP_W'(1));
	assign sts.is_final    = cfg.final_mask[run_state_q];
	assign sts.limit_hit   = (steps_q >= cfg.end_step_limit);
	assign sts.clr_last    = (clr_q == '1);
	assign result          = result_q;
endmodule

// ===== design/pdr_controller.sv =====
// Controller state machine that sequences the recognizer datapath.
`timescale 1ns / 1ps
module pdr_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  pdr_pkg::sts_t sts,
	output pdr_pkg::cmd_t cmd
);
	import pdr_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DISP, S_RULE_WR, S_MV_RD, S_MV_EV, S_POP_LD,
		S_END_CHK, S_FIN
	} state_t;

	state_t state_q;
	logic   clr_reply_q;
	logic   out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.load       = in_valid && (state_q == S_IDLE);
		cmd.start      = (state_q == S_DISP) && (sts.mode == MODE_START);
		cmd.end_init   = (state_q == S_DISP) && (sts.mode == MODE_END);
		cmd.rule_upd   = (state_q == S_RULE_WR);
		cmd.move_apply = (state_q == S_MV_EV);
		cmd.step_inc   = (state_q == S_MV_EV) && !sts.move_fail && (sts.mode == MODE_END);
		cmd.pop_load   = (state_q == S_POP_LD);
		cmd.end_check  = (state_q == S_END_CHK);
		cmd.clr_run    = (state_q == S_CLEAR);
		cmd.capture    = (state_q == S_FIN) && (!out_valid_q || out_ready);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_reply_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= clr_reply_q ? S_FIN : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					unique case (sts.mode) inside
						MODE_WRITE, MODE_DELETE: state_q <= S_RULE_WR;
						MODE_SYMBOL: state_q <= sts.halted ? S_FIN : S_MV_EV;
						MODE_END: state_q <= sts.halted ? S_FIN : S_END_CHK;
						MODE_CLEAR: begin
							clr_reply_q <= 1'b1;
							state_q     <= S_CLEAR;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_RULE_WR: state_q <= S_FIN;
				S_MV_RD: state_q <= S_MV_EV;
				S_MV_EV: begin
					if (sts.move_fail) begin
						state_q <= S_FIN;
					end else if (sts.move_pop_ld) begin
						state_q <= S_POP_LD;
					end else begin
						state_q <= (sts.mode == MODE_END) ? S_END_CHK : S_FIN;
					end
				end
				S_POP_LD: state_q <= (sts.mode == MODE_END) ? S_END_CHK : S_FIN;
				S_END_CHK: state_q <= (sts.is_final || sts.limit_hit) ? S_FIN : S_MV_RD;
				S_FIN: begin
					if (cmd.capture) begin
						clr_reply_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== design/pushdown_automaton_recognizer_core.sv =====
// Top level of the pushdown recognizer: configuration registers and core.
// Each item runs S_DISP, then S_FIN; rule write or delete puts S_RULE_WR between.
// Unless halted, a symbol puts S_MV_EV (and S_POP_LD if a pop leaves a symbol)
// between, and end input loops S_END_CHK, S_MV_RD, S_MV_EV (S_POP_LD) per move.
// Each move: one table read, at most one stack update; one item at a time. Reset and
// clear table walk 4096 entries, input not ready. Config resets to 0, 0, 1, 15, 64.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pushdown_automaton_recognizer_core (
	input  logic        clk,
	input  logic        arst_n,
	pdr_in_if.sink      in_ch,
	pdr_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pdr_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	sts_t    sts;
	item_t   item;
	result_t result;
	logic    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_state    <= '0;
			cfg_q.final_mask     <= '0;
			cfg_q.bottom_symbol  <= SYMBOL_BITS'(1);
			cfg_q.end_symbol     <= SYMBOL_BITS'(15);
			cfg_q.end_step_limit <= 8'd64;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_START_STATE: cfg_q.start_state <= pwdata[STATE_BITS-1:0];
				REG_FINAL_MASK:  cfg_q.final_mask <= pwdata[NSTATES-1:0];
				REG_BOTTOM_SYM:  cfg_q.bottom_symbol <= pwdata[SYMBOL_BITS-1:0];
				REG_END_SYM:     cfg_q.end_symbol <= pwdata[SYMBOL_BITS-1:0];
				REG_STEP_LIMIT:  cfg_q.end_step_limit <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[4:2])
			REG_START_STATE: prdata = 32'(cfg_q.start_state);
			REG_FINAL_MASK:  prdata = 32'(cfg_q.final_mask);
			REG_BOTTOM_SYM:  prdata = 32'(cfg_q.bottom_symbol);
			REG_END_SYM:     prdata = 32'(cfg_q.end_symbol);
			REG_STEP_LIMIT:  prdata = 32'(cfg_q.end_step_limit);
			default:         prdata = '0;
		endcase
	end

	assign item = '{mode: in_ch.mode, rule_state: in_ch.rule_state,
		symbol: in_ch.symbol, rule_stack_symbol: in_ch.rule_stack_symbol,
		rule_next_state: in_ch.rule_next_state, event_kind: in_ch.event_kind,
		event_first: in_ch.event_first, event_second: in_ch.event_second};

	pdr_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pdr_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.item   (item),
		.sts    (sts),
		.result (result)
	);

	assign out_ch.status        = result.status;
	assign out_ch.current_state = result.current_state;
	assign out_ch.stack_top     = result.stack_top;
	assign out_ch.stack_depth   = result.stack_depth;

	`PDR_ASSERT_IMP(a_depth_bound, out_ch.valid, out_ch.stack_depth <= SP_W'(STACK_DEPTH))
	`PDR_ASSERT_IMP(a_empty_top, out_ch.valid && (out_ch.stack_depth == '0), out_ch.stack_top == '0)
	`PDR_ASSERT_IMP(a_capture_free, cmd.capture, !out_ch.valid || out_ch.ready)
	`PDR_ASSERT(a_one_update, $onehot0({cmd.start, cmd.rule_upd, cmd.move_apply, cmd.pop_load, cmd.clr_run}))
endmodule

// ===== tb/pushdown_automaton_recognizer_core_test.sv =====
// Self-checking testbench of the pushdown recognizer: directed and random transactions.
`timescale 1ns / 1ps
module pushdown_automaton_recognizer_core_test;
	import pdr_pkg::*;

	localparam int ITEM_W = $bits(item_t);

	class recognizer_scoreboard;
		entry_t rules [0:4095];
		int unsigned combo_count [0:255];
		logic [3:0] stack_mem [0:63];
		int unsigned depth;
		logic [3:0] state;
		bit halted;
		cfg_t cfg;
		result_t pending [$];
		int unsigned errors;

		function new();
			clear_rules();
			depth = 0;
			state = 0;
			halted = 1;
			errors = 0;
			cfg.start_state = 0;
			cfg.final_mask = 0;
			cfg.bottom_symbol = 1;
			cfg.end_symbol = 15;
			cfg.end_step_limit = 64;
		endfunction

		function void clear_rules();
			foreach (rules[i]) rules[i] = '0;
			foreach (combo_count[i]) combo_count[i] = 0;
		endfunction

		function logic [3:0] top_sym();
			return depth != 0 ? stack_mem[depth - 1] : 4'd0;
		endfunction

		function logic [3:0] try_move(logic [3:0] sym);
			logic [3:0] top;
			entry_t r;
			top = top_sym();
			if (combo_count[{state, sym}] == 0) return ST_NORULE_SYM;
			r = rules[{state, sym, top}];
			if (!r.valid) return ST_NORULE_TOP;
			if (r.kind == EV_CHECK) begin
				if (r.first != top) return ST_MISMATCH;
			end else if (r.kind == EV_POP) begin
				if (depth == 0) return ST_POP_EMPTY;
				depth--;
			end else if (r.second == top) begin
				if (depth >= STACK_DEPTH) return ST_OVERFLOW;
				stack_mem[depth] = r.first;
				depth++;
			end
			state = r.next;
			return ST_OK;
		endfunction

		function void note_item(item_t it);
			logic [11:0] key;
			logic [3:0] st;
			int unsigned steps;
			result_t res;
			key = {it.rule_state, it.symbol, it.rule_stack_symbol};
			st = ST_OK;
			case (it.mode)
				MODE_WRITE: begin
					if (rules[key].valid) st = ST_EXISTS;
					else begin
						rules[key] = {1'b1, it.rule_next_state, it.event_kind,
							it.event_first, it.event_second};
						combo_count[key[11:4]]++;
						st = ST_WRITTEN;
					end
				end
				MODE_DELETE: begin
					if (!rules[key].valid) st = ST_ABSENT;
					else begin
						rules[key] = '0;
						if (combo_count[key[11:4]] != 0) combo_count[key[11:4]]--;
						st = ST_DELETED;
					end
				end
				MODE_START: begin
					state = cfg.start_state;
					stack_mem[0] = cfg.bottom_symbol;
					depth = 1;
					halted = 0;
				end
				MODE_SYMBOL: begin
					if (!halted) begin
						st = try_move(it.symbol);
						if (st != ST_OK) halted = 1;
					end
				end
				MODE_END: begin
					if (!halted) begin
						steps = 0;
						forever begin
							if (cfg.final_mask[state]) begin
								st = ST_ACCEPTED;
								break;
							end
							if (steps >= cfg.end_step_limit) begin
								st = ST_NO_HALT;
								break;
							end
							st = try_move(cfg.end_symbol);
							if (st != ST_OK) break;
							steps++;
						end
						halted = 1;
					end
				end
				MODE_CLEAR: clear_rules();
				default: ;
			endcase
			res.status = st;
			res.current_state = state;
			res.stack_top = top_sym();
			res.stack_depth = SP_W'(depth);
			pending = {pending, res};
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result status %0d", got.status);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status) begin
				$error("status: expected %0d, actual %0d", exp.status, got.status);
				errors++;
			end
			if (got.current_state !== exp.current_state) begin
				$error("current_state: expected %0d, actual %0d",
					exp.current_state, got.current_state);
				errors++;
			end
			if (got.stack_top !== exp.stack_top) begin
				$error("stack_top: expected %0d, actual %0d", exp.stack_top, got.stack_top);
				errors++;
			end
			if (got.stack_depth !== exp.stack_depth) begin
				$error("stack_depth: expected %0d, actual %0d",
					exp.stack_depth, got.stack_depth);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	bit stim_done = 0;
	int unsigned hold_off_cycles = 0;

	pdr_in_if in_ch ();
	pdr_out_if out_ch ();

	pushdown_automaton_recognizer_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	recognizer_scoreboard sb = new();

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	initial begin
		in_ch.valid = 0;
		in_ch.mode = 0;
		in_ch.rule_state = 0;
		in_ch.symbol = 0;
		in_ch.rule_stack_symbol = 0;
		in_ch.rule_next_state = 0;
		in_ch.event_kind = 0;
		in_ch.event_first = 0;
		in_ch.event_second = 0;
		out_ch.ready = 0;
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_START_STATE: sb.cfg.start_state = value[3:0];
			REG_FINAL_MASK: sb.cfg.final_mask = value[15:0];
			REG_BOTTOM_SYM: sb.cfg.bottom_symbol = value[3:0];
			REG_END_SYM: sb.cfg.end_symbol = value[3:0];
			default: sb.cfg.end_step_limit = value[7:0];
		endcase
	endtask

	task automatic send_item(item_t it);
		int gap;
		gap = $urandom_range(0, 3);
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid <= 0;
		end
		@(negedge clk);
		in_ch.valid <= 1;
		in_ch.mode <= it.mode;
		in_ch.rule_state <= it.rule_state;
		in_ch.symbol <= it.symbol;
		in_ch.rule_stack_symbol <= it.rule_stack_symbol;
		in_ch.rule_next_state <= it.rule_next_state;
		in_ch.event_kind <= it.event_kind;
		in_ch.event_first <= it.event_first;
		in_ch.event_second <= it.event_second;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_item(it);
	endtask

	task automatic end_valid();
		@(negedge clk);
		in_ch.valid <= 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (900) @(posedge clk);
	endtask

	function automatic item_t rule_item(logic [2:0] m, int unsigned s, int unsigned y,
		int unsigned t, int unsigned n, int unsigned k, int unsigned f, int unsigned e);
		item_t it;
		it.mode = m;
		it.rule_state = 4'(s);
		it.symbol = 4'(y);
		it.rule_stack_symbol = 4'(t);
		it.rule_next_state = 4'(n);
		it.event_kind = 2'(k);
		it.event_first = 4'(f);
		it.event_second = 4'(e);
		return it;
	endfunction

	function automatic item_t random_item();
		item_t it;
		it = item_t'(ITEM_W'({$urandom, $urandom}));
		it.mode = 3'($urandom_range(0, 7));
		return it;
	endfunction

	// A random language over states 0..3 and symbols 1..3 keeps runs alive.
	task automatic random_phase(int unsigned count);
		item_t it;
		int unsigned n;
		int unsigned r;
		for (n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				it = rule_item(MODE_WRITE, $urandom_range(0, 3), $urandom_range(1, 3),
					$urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
					$urandom_range(0, 3), $urandom_range(0, 3));
			else if (r < 35)
				it = rule_item(MODE_DELETE, $urandom_range(0, 3), $urandom_range(1, 3),
					$urandom_range(0, 3), 0, 0, 0, 0);
			else if (r < 45)
				it = rule_item(MODE_START, 0, 0, 0, 0, 0, 0, 0);
			else if (r < 80)
				it = rule_item(MODE_SYMBOL, 0, $urandom_range(1, 3), 0, 0, 0, 0, 0);
			else if (r < 88)
				it = rule_item(MODE_END, 0, 0, 0, 0, 0, 0, 0);
			else if (r < 89)
				it = rule_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0);
			else
				it = random_item();
			if (it.mode == MODE_CLEAR && $urandom_range(0, 3) != 0) it.mode = MODE_START;
			send_item(it);
		end
		end_valid();
	endtask

	always begin
		@(negedge clk);
		if (hold_off_cycles != 0) begin
			out_ch.ready <= 0;
			repeat (hold_off_cycles) @(negedge clk);
			hold_off_cycles = 0;
		end
		if ($urandom_range(0, 3) == 0 || sb.pending.size() > 40) out_ch.ready <= 1;
		else out_ch.ready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result({out_ch.status, out_ch.current_state, out_ch.stack_top,
				out_ch.stack_depth});
	end

	initial begin
		int i;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_item(rule_item(MODE_SYMBOL, 0, 1, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_END, 0, 0, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_WRITE, 0, 1, 1, 1, 2, 15, 1));
		send_item(rule_item(MODE_WRITE, 0, 1, 1, 1, 2, 15, 1));
		send_item(rule_item(MODE_WRITE, 1, 2, 15, 1, 1, 0, 0));
		send_item(rule_item(MODE_WRITE, 1, 2, 1, 2, 0, 3, 0));
		send_item(rule_item(MODE_WRITE, 1, 3, 15, 1, 3, 15, 15));
		send_item(rule_item(MODE_START, 0, 0, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_SYMBOL, 0, 1, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_SYMBOL, 0, 15, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_START, 0, 0, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_SYMBOL, 0, 1, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_SYMBOL, 0, 2, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_SYMBOL, 0, 2, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_START, 0, 0, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_SYMBOL, 0, 1, 0, 0, 0, 0, 0));
		for (i = 0; i < 66; i++) send_item(rule_item(MODE_SYMBOL, 0, 3, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_DELETE, 1, 2, 1, 0, 0, 0, 0));
		send_item(rule_item(MODE_DELETE, 1, 2, 1, 0, 0, 0, 0));
		send_item(rule_item(MODE_END, 0, 0, 0, 0, 0, 0, 0));
		send_item(rule_item(3'd6, 15, 15, 15, 15, 3, 15, 15));
		send_item(rule_item(3'd7, 0, 0, 0, 0, 0, 0, 0));
		end_valid();
		drain();

		write_reg(REG_START_STATE, 1);
		write_reg(REG_FINAL_MASK, 16'h8000);
		write_reg(REG_BOTTOM_SYM, 15);
		write_reg(REG_END_SYM, 2);
		write_reg(REG_STEP_LIMIT, 255);
		send_item(rule_item(MODE_WRITE, 1, 2, 15, 15, 0, 15, 0));
		send_item(rule_item(MODE_START, 0, 0, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_END, 0, 0, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_WRITE, 1, 2, 1, 1, 1, 0, 0));
		send_item(rule_item(MODE_WRITE, 1, 2, 0, 1, 1, 0, 0));
		send_item(rule_item(MODE_START, 0, 0, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_END, 0, 0, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_START, 0, 0, 0, 0, 0, 0, 0));
		send_item(rule_item(MODE_END, 0, 0, 0, 0, 0, 0, 0));
		end_valid();
		drain();

		write_reg(REG_START_STATE, 0);
		write_reg(REG_FINAL_MASK, 16'h0008);
		write_reg(REG_BOTTOM_SYM, 1);
		write_reg(REG_END_SYM, 3);
		write_reg(REG_STEP_LIMIT, 1);
		hold_off_cycles = 300;
		random_phase(600);
		drain();

		write_reg(REG_START_STATE, 15);
		write_reg(REG_FINAL_MASK, 16'hFFFF);
		write_reg(REG_STEP_LIMIT, 0);
		random_phase(200);
		drain();

		write_reg(REG_START_STATE, $urandom_range(0, 3));
		write_reg(REG_FINAL_MASK, $urandom_range(0, 15));
		write_reg(REG_BOTTOM_SYM, $urandom_range(1, 3));
		write_reg(REG_END_SYM, $urandom_range(1, 3));
		write_reg(REG_STEP_LIMIT, $urandom_range(2, 20));
		random_phase(900);
		drain();
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

// ===== pushdown_automaton_recognizer_core.f =====
+incdir+design
design/pdr_pkg.sv
design/pdr_in_if.sv
design/pdr_out_if.sv
design/pdr_ram.sv
design/pdr_datapath.sv
design/pdr_controller.sv
design/pushdown_automaton_recognizer_core.sv
tb/pushdown_automaton_recognizer_core_test.sv
